@@ src/mck_pkg.sv @@
// Shared types, constants and the Morse code table for the character keyer.
// Used by mck_front, mck_cmd_queue, mck_back and morse_character_keyer.
`timescale 1ns / 1ps
`default_nettype none
package mck_pkg;

  localparam int DUR_W     = 16;
  localparam int CHAR_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W     = 3;
  localparam int DASH_W    = 5;
  localparam int SEL_W     = 6;

  // Character constants
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;  // ' '
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;  // 'a' - 'A'
  localparam logic [SEL_W-1:0]  DIGIT_BASE   = 6'd26;  // digits follow the letters

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DOT_TIME        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH_TIME       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_GAP_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHAR_GAP_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_GAP_TIME   = 3'd4;

  // Configuration reset values
  localparam logic [DUR_W-1:0] RST_DOT_TIME        = 16'd500;
  localparam logic [DUR_W-1:0] RST_DASH_TIME       = 16'd1000;
  localparam logic [DUR_W-1:0] RST_SYMBOL_GAP_TIME = 16'd50;
  localparam logic [DUR_W-1:0] RST_CHAR_GAP_TIME   = 16'd50;
  localparam logic [DUR_W-1:0] RST_WORD_GAP_TIME   = 16'd1500;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_SPACE,
    KIND_UNSUP
  } kind_t;

  // Classified character, passed from front to back
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic [DASH_W-1:0] dash_bits;  // bit i set: symbol i is a dash
  } cmd_t;

  typedef struct packed {
    logic [DUR_W-1:0] dot_time;
    logic [DUR_W-1:0] dash_time;
    logic [DUR_W-1:0] symbol_gap_time;
    logic [DUR_W-1:0] char_gap_time;
    logic [DUR_W-1:0] word_gap_time;
  } timing_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LIT,
    PH_GAP,
    PH_TAIL
  } phase_t;

  // Morse table: {len, dash_bits}, letters A..Z then digits 0..9
  function automatic logic [LEN_W+DASH_W-1:0] code_lookup(input logic [SEL_W-1:0] sel);
    logic [LEN_W+DASH_W-1:0] e;
    unique case (sel)
      6'd0:  e = {3'd2, 5'h02};  // A .-
      6'd1:  e = {3'd4, 5'h01};  // B -...
      6'd2:  e = {3'd4, 5'h05};  // C -.-.
      6'd3:  e = {3'd3, 5'h01};  // D -..
      6'd4:  e = {3'd1, 5'h00};  // E .
      6'd5:  e = {3'd4, 5'h04};  // F ..-.
      6'd6:  e = {3'd3, 5'h03};  // G --.
      6'd7:  e = {3'd4, 5'h00};  // H ....
      6'd8:  e = {3'd2, 5'h00};  // I ..
      6'd9:  e = {3'd4, 5'h0E};  // J .---
      6'd10: e = {3'd3, 5'h05};  // K -.-
      6'd11: e = {3'd4, 5'h02};  // L .-..
      6'd12: e = {3'd2, 5'h03};  // M --
      6'd13: e = {3'd2, 5'h01};  // N -.
      6'd14: e = {3'd3, 5'h07};  // O ---
      6'd15: e = {3'd4, 5'h06};  // P .--.
      6'd16: e = {3'd4, 5'h0B};  // Q --.-
      6'd17: e = {3'd3, 5'h02};  // R .-.
      6'd18: e = {3'd3, 5'h00};  // S ...
      6'd19: e = {3'd1, 5'h01};  // T -
      6'd20: e = {3'd3, 5'h04};  // U ..-
      6'd21: e = {3'd4, 5'h08};  // V ...-
      6'd22: e = {3'd3, 5'h06};  // W .--
      6'd23: e = {3'd4, 5'h09};  // X -..-
      6'd24: e = {3'd4, 5'h0D};  // Y -.--
      6'd25: e = {3'd4, 5'h03};  // Z --..
      6'd26: e = {3'd5, 5'h1F};  // 0 -----
      6'd27: e = {3'd5, 5'h1E};  // 1 .----
      6'd28: e = {3'd5, 5'h1C};  // 2 ..---
      6'd29: e = {3'd5, 5'h18};  // 3 ...--
      6'd30: e = {3'd5, 5'h10};  // 4 ....-
      6'd31: e = {3'd5, 5'h00};  // 5 .....
      6'd32: e = {3'd5, 5'h01};  // 6 -....
      6'd33: e = {3'd5, 5'h03};  // 7 --...
      6'd34: e = {3'd5, 5'h07};  // 8 ---..
      6'd35: e = {3'd5, 5'h0F};  // 9 ----.
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ src/mck_front.sv @@
// Front end: takes a character transfer and classifies it into a keying command.
// Depends on mck_pkg (cmd_t, code_lookup, character constants).
`timescale 1ns / 1ps
`default_nettype none
module mck_front (
  input  wire logic                      push,
  input  wire logic [mck_pkg::CHAR_W-1:0] char_code,
  input  wire logic                      q_full,
  output logic                           q_push,
  output mck_pkg::cmd_t                  q_data
);
  import mck_pkg::*;

  logic [CHAR_W-1:0]        upper;
  logic [CHAR_W-1:0]        letter_off;
  logic [CHAR_W-1:0]        digit_off;
  logic                     is_letter;
  logic                     is_digit;
  logic [SEL_W-1:0]         sel;
  logic [LEN_W+DASH_W-1:0]  entry;

  // Fold lower case to upper case
  always_comb begin
    if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z) begin
      upper = char_code - CASE_OFFSET;
    end else begin
      upper = char_code;
    end
  end

  // Table index for letters and digits
  assign is_letter  = (upper >= CHAR_UPPER_A) && (upper <= CHAR_UPPER_Z);
  assign is_digit   = (upper >= CHAR_ZERO) && (upper <= CHAR_NINE);
  assign letter_off = upper - CHAR_UPPER_A;
  assign digit_off  = upper - CHAR_ZERO;
  assign sel        = is_letter ? letter_off[SEL_W-1:0]
                                : (digit_off[SEL_W-1:0] + DIGIT_BASE);
  assign entry      = code_lookup(sel);

  // Build the command
  always_comb begin
    q_data = '0;
    priority if (upper == CHAR_SPACE) begin
      q_data.kind = KIND_SPACE;
    end else if (is_letter || is_digit) begin
      q_data.kind      = KIND_CODE;
      q_data.len       = entry[LEN_W+DASH_W-1:DASH_W];
      q_data.dash_bits = entry[DASH_W-1:0];
    end else begin
      q_data.kind = KIND_UNSUP;
    end
  end

  assign q_push = push && !q_full;

endmodule
`default_nettype wire

@@ src/mck_cmd_queue.sv @@
// Short command queue that decouples the classifier from the segment sequencer.
// Depends on mck_pkg (cmd_t).
`timescale 1ns / 1ps
`default_nettype none
module mck_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  mck_pkg::cmd_t      wdata,
  output logic               full,
  input  wire logic          pop,
  output mck_pkg::cmd_t      rdata,
  output logic               empty
);
  import mck_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("command queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("command queue count did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("command queue count did not shrink on pop");

endmodule
`default_nettype wire

@@ src/mck_back.sv @@
// Back end: walks one command through its lamp segments into an output register.
// Depends on mck_pkg (cmd_t, timing_t, phase_t).
`timescale 1ns / 1ps
`default_nettype none
module mck_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  mck_pkg::timing_t                timing,
  input  mck_pkg::cmd_t                   q_data,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  input  wire logic                       pop,
  output logic                            empty,
  output logic                            lamp_on,
  output logic [mck_pkg::DUR_W-1:0]       duration_ms,
  output logic                            unsupported,
  output logic                            last
);
  import mck_pkg::*;

  phase_t            phase;
  phase_t            phase_next;
  logic [LEN_W-1:0]  remain;
  logic [DASH_W-1:0] bits;
  logic              tail_word;
  logic              tail_unsup;
  logic              out_valid;
  logic              adv;
  logic              emit;
  logic              seg_lamp;
  logic [DUR_W-1:0]  seg_dur;
  logic              seg_unsup;
  logic              seg_last;

  // Output register may take a new segment when empty or being drained
  assign adv   = !out_valid || pop;
  assign empty = !out_valid;

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  // Next phase and segment contents
  always_comb begin
    phase_next = phase;
    q_pop      = 1'b0;
    emit       = 1'b0;
    seg_lamp   = 1'b0;
    seg_dur    = timing.symbol_gap_time;
    seg_unsup  = 1'b0;
    seg_last   = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          phase_next = (q_data.kind == KIND_CODE) ? PH_LIT : PH_TAIL;
        end
      end
      PH_LIT: begin
        emit     = adv;
        seg_lamp = 1'b1;
        seg_dur  = bits[0] ? timing.dash_time : timing.dot_time;
        if (adv) begin
          phase_next = PH_GAP;
        end
      end
      PH_GAP: begin
        emit = adv;
        if (adv) begin
          phase_next = (remain == LEN_W'(1)) ? PH_TAIL : PH_LIT;
        end
      end
      PH_TAIL: begin
        emit      = adv;
        seg_dur   = tail_word ? timing.word_gap_time : timing.char_gap_time;
        seg_unsup = tail_unsup;
        seg_last  = 1'b1;
        if (adv) begin
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Working copy of the current command
  always_ff @(posedge clk) begin
    if (q_pop) begin
      remain     <= q_data.len;
      bits       <= q_data.dash_bits;
      tail_word  <= (q_data.kind == KIND_SPACE);
      tail_unsup <= (q_data.kind == KIND_UNSUP);
    end else if (phase == PH_GAP && adv) begin
      remain <= remain - 1'b1;
      bits   <= bits >> 1;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      lamp_on     <= seg_lamp;
      duration_ms <= seg_dur;
      unsupported <= seg_unsup;
      last        <= seg_last;
    end
  end

  a_tail_marks_last: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TAIL && adv) |=> (out_valid && last))
    else $error("character tail segment not marked last");

  a_gap_has_symbols: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LIT || phase == PH_GAP) |-> (remain != '0))
    else $error("symbol phase with no symbols left");

  a_lit_then_gap: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LIT && adv) |=> (phase == PH_GAP && out_valid && lamp_on))
    else $error("lit segment not followed by symbol gap");

endmodule
`default_nettype wire

@@ src/morse_character_keyer.sv @@
// Morse character keyer: takes ASCII characters and gives lamp keying segments.
// First segment of a character: command queue, phase register, then output register.
// Sequencer: one segment per cycle while the output is free or popped; each character
//   loads in an idle phase, then gives a lit segment and a gap per symbol and a tail.
// Reset: timing registers take their default values; command queue and output empty.
// Depends on mck_pkg, mck_front, mck_cmd_queue and mck_back.
`timescale 1ns / 1ps
`default_nettype none
module morse_character_keyer #(
  parameter int CMD_QUEUE_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // character input
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [mck_pkg::CHAR_W-1:0]     char_code,
  // segment output
  output logic                                empty,
  input  wire logic                           pop,
  output logic                                lamp_on,
  output logic [mck_pkg::DUR_W-1:0]           duration_ms,
  output logic                                unsupported,
  output logic                                last,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mck_pkg::DUR_W-1:0]      cfg_data
);
  import mck_pkg::*;

  timing_t timing;
  cmd_t    front_data;
  cmd_t    queue_data;
  logic    front_push;
  logic    queue_full;
  logic    queue_empty;
  logic    queue_pop;

  // Timing registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.dot_time        <= RST_DOT_TIME;
      timing.dash_time       <= RST_DASH_TIME;
      timing.symbol_gap_time <= RST_SYMBOL_GAP_TIME;
      timing.char_gap_time   <= RST_CHAR_GAP_TIME;
      timing.word_gap_time   <= RST_WORD_GAP_TIME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DOT_TIME:        timing.dot_time        <= cfg_data;
        REG_DASH_TIME:       timing.dash_time       <= cfg_data;
        REG_SYMBOL_GAP_TIME: timing.symbol_gap_time <= cfg_data;
        REG_CHAR_GAP_TIME:   timing.char_gap_time   <= cfg_data;
        REG_WORD_GAP_TIME:   timing.word_gap_time   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign full = queue_full;

  mck_front u_front (
    .push      (push),
    .char_code (char_code),
    .q_full    (queue_full),
    .q_push    (front_push),
    .q_data    (front_data)
  );

  mck_cmd_queue #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_push),
    .wdata (front_data),
    .full  (queue_full),
    .pop   (queue_pop),
    .rdata (queue_data),
    .empty (queue_empty)
  );

  mck_back u_back (
    .clk         (clk),
    .rst         (rst),
    .timing      (timing),
    .q_data      (queue_data),
    .q_empty     (queue_empty),
    .q_pop       (queue_pop),
    .pop         (pop),
    .empty       (empty),
    .lamp_on     (lamp_on),
    .duration_ms (duration_ms),
    .unsupported (unsupported),
    .last        (last)
  );

endmodule
`default_nettype wire
